### hdl/nrr_pkg.sv
// nrr_pkg: shared types, constants and the multi-byte nop table for the nop run rewriter
// no dependencies
package nrr_pkg;

  localparam logic [7:0] NopByte      = 8'h90;
  localparam int unsigned NopMax      = 9;
  localparam int unsigned CmdFifoDepth = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  // one command: a nop of nop_len bytes, then optionally the literal byte
  typedef struct packed {
    logic [3:0] nop_len;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] nop_table_byte(input logic [3:0] len, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      4'd1: b = 8'h90;
      4'd2: b = (idx == 4'd0) ? 8'h66 : 8'h90;
      4'd3: begin
        if (idx == 4'd0) b = 8'h0F;
        else if (idx == 4'd1) b = 8'h1F;
      end
      4'd4: begin
        if (idx == 4'd0) b = 8'h0F;
        else if (idx == 4'd1) b = 8'h1F;
        else if (idx == 4'd2) b = 8'h40;
      end
      4'd5: begin
        if (idx == 4'd0) b = 8'h0F;
        else if (idx == 4'd1) b = 8'h1F;
        else if (idx == 4'd2) b = 8'h44;
      end
      4'd6: begin
        if (idx == 4'd0) b = 8'h66;
        else if (idx == 4'd1) b = 8'h0F;
        else if (idx == 4'd2) b = 8'h1F;
        else if (idx == 4'd3) b = 8'h44;
      end
      4'd7: begin
        if (idx == 4'd0) b = 8'h0F;
        else if (idx == 4'd1) b = 8'h1F;
        else if (idx == 4'd2) b = 8'h80;
      end
      4'd8: begin
        if (idx == 4'd0) b = 8'h0F;
        else if (idx == 4'd1) b = 8'h1F;
        else if (idx == 4'd2) b = 8'h84;
      end
      4'd9: begin
        if (idx == 4'd0) b = 8'h66;
        else if (idx == 4'd1) b = 8'h0F;
        else if (idx == 4'd2) b = 8'h1F;
        else if (idx == 4'd3) b = 8'h84;
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/nop_run_rewriter_core.sv
// nop_run_rewriter_core: top level of the 0x90 run to multi-byte nop rewriter
// depends on nrr_pkg, nrr_front, nrr_cmd_fifo, nrr_back
// Rewrites a byte stream into one of equal length, turning each run of 0x90 into the
// recommended multi-byte nop encodings (9-byte groups, then one nop of the remaining length).
// The front end takes one input transaction per cycle and queues a command whenever an item
// produces output; the back end emits one output byte per cycle unless out_ready_i stalls
// it, so a byte per cycle is sustained. Commands pass the queue and a command register.
// Input ready drops only when the FifoDepth-entry command queue is full, which happens only
// if the output side stalls or a nop burst lags behind more than FifoDepth pending commands.
module nop_run_rewriter_core import nrr_pkg::*; #(
  parameter int unsigned FifoDepth = CmdFifoDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic push, pop, full, empty;
  cmd_t push_cmd, pop_cmd;

  nrr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  nrr_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  nrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (empty),
    .fifo_data_i  (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

### hdl/nrr_front.sv
// nrr_front: accepts input transactions, tracks the pending 0x90 run and issues commands
// depends on nrr_pkg
module nrr_front import nrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     fifo_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [3:0] cnt_q, cnt_d;
  logic [3:0] cnt_sat, cnt_inc;
  logic       accept, is_nop, emit;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_sat    = (cnt_q > 4'(NopMax - 1)) ? 4'(NopMax - 1) : cnt_q;
  assign cnt_inc    = cnt_sat + 4'd1;
  assign is_nop     = (in_data_i.data_byte == NopByte);

  always_comb begin
    cmd_o.data_byte = in_data_i.data_byte;
    cmd_o.last      = in_data_i.end_of_buffer;
    if (is_nop) begin
      emit           = (cnt_inc == 4'(NopMax)) || in_data_i.end_of_buffer;
      cmd_o.nop_len  = cnt_inc;
      cmd_o.has_byte = 1'b0;
      cnt_d          = emit ? 4'd0 : cnt_inc;
    end else begin
      emit           = 1'b1;
      cmd_o.nop_len  = cnt_sat;
      cmd_o.has_byte = 1'b1;
      cnt_d          = 4'd0;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/nrr_cmd_fifo.sv
// nrr_cmd_fifo: command queue between front and back end
// depends on nrr_pkg
module nrr_cmd_fifo import nrr_pkg::*; #(
  parameter int unsigned Depth = CmdFifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

### hdl/nrr_back.sv
// nrr_back: expands queued commands into output bytes, one per cycle unless out_ready_i stalls it
// depends on nrr_pkg
module nrr_back import nrr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fifo_empty_i,
  input  cmd_t      fifo_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cmd_t       cmd_q;
  logic       vld_q;
  logic [3:0] pos_q;
  logic [3:0] total;
  logic       is_final, fire;

  assign total    = cmd_q.nop_len + {3'b000, cmd_q.has_byte};
  assign is_final = (pos_q == total - 4'd1);
  assign fire     = vld_q && out_ready_i;
  assign pop_o    = (!vld_q || (fire && is_final)) && !fifo_empty_i;

  assign out_valid_o           = vld_q;
  assign out_data_o.out_byte   = (pos_q < cmd_q.nop_len) ?
                                 nop_table_byte(cmd_q.nop_len, pos_q) : cmd_q.data_byte;
  assign out_data_o.run_last   = is_final;
  assign out_data_o.stream_end = is_final && cmd_q.last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= fifo_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pos_q <= 4'd0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      pos_q <= 4'd0;
    end else if (fire) begin
      if (is_final) begin
        vld_q <= 1'b0;
        pos_q <= 4'd0;
      end else begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  a_cmd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (total != 4'd0) && (total <= 4'(NopMax)))
    else $error("back end holds an empty or oversized command");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (pos_q < total))
    else $error("byte position beyond command length");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_final) |=> vld_q && (pos_q == $past(pos_q) + 4'd1))
    else $error("command did not advance after a transaction");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> vld_q && $stable(pos_q))
    else $error("back end moved while stalled");

endmodule
